// ----- hw/rtl/cnad_pkg.sv -----
// Shared types, constants and lookup functions for the cpio newc deframer.
`default_nettype none

package cnad_pkg;

   // Header layout
   localparam int unsigned NUM_FIELDS     = 13;
   localparam int unsigned FIELD_W        = 32;
   localparam logic [6:0]  HDR_LAST_IDX   = 7'd109;
   localparam logic [6:0]  MAGIC_LEN      = 7'd6;
   localparam logic [6:0]  MAGIC_LAST_IDX = 7'd5;
   localparam logic [3:0]  LAST_FIELD     = 4'd12;
   localparam logic [3:0]  FIELD_FILESIZE = 4'd6;
   localparam logic [3:0]  FIELD_NAMESIZE = 4'd11;
   localparam logic [3:0]  TRAILER_LEN    = 4'd11;

   // ASCII codes used by the parser
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_2     = 8'h32;
   localparam logic [7:0] CHAR_7     = 8'h37;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] OFFSET_DIG = 8'd48;
   localparam logic [7:0] OFFSET_UC  = 8'd55;
   localparam logic [7:0] OFFSET_LC  = 8'd87;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_NAME     = 3'd1,
      PH_NAME_PAD = 3'd2,
      PH_DATA     = 3'd3,
      PH_DATA_PAD = 3'd4,
      PH_STOP     = 3'd5
   } cnad_phase_type;

   typedef enum logic [2:0] {
      KIND_NAME  = 3'd0,
      KIND_ENTRY = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_LAST  = 3'd3,
      KIND_END   = 3'd4,
      KIND_BAD   = 3'd5
   } cnad_kind_type;

   // Decoded header values carried with an entry record
   typedef struct packed {
      logic [63:0] ref_device_pair;
      logic [63:0] device_pair;
      logic [31:0] data_length;
      logic [31:0] mod_time;
      logic [31:0] link_count;
      logic [31:0] owner_gid;
      logic [31:0] owner_uid;
      logic [31:0] file_mode;
      logic [31:0] inode;
   } cnad_rec_type;

   // One queue entry: the results caused by one archive byte
   typedef struct packed {
      cnad_kind_type kind_a;
      logic          has_second;
      cnad_kind_type kind_b;
      logic [7:0]    byte_value;
      cnad_rec_type  rec;
   } cnad_cmd_type;

   typedef struct packed {
      logic         valid;
      cnad_cmd_type cmd;
   } cnad_push_type;

   typedef struct packed {
      logic         valid;
      cnad_cmd_type cmd;
   } cnad_head_type;

   // Expected magic character at header positions zero to four
   function automatic logic [7:0] magic_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = CHAR_0;
         3'd1:    ch = CHAR_7;
         3'd2:    ch = CHAR_0;
         3'd3:    ch = CHAR_7;
         3'd4:    ch = CHAR_0;
         default: ch = CHAR_0;
      endcase
      return ch;
   endfunction

   // "TRAILER!!!" followed by a zero byte
   function automatic logic [7:0] trailer_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h54;
         4'd1:    ch = 8'h52;
         4'd2:    ch = 8'h41;
         4'd3:    ch = 8'h49;
         4'd4:    ch = 8'h4C;
         4'd5:    ch = 8'h45;
         4'd6:    ch = 8'h52;
         4'd7:    ch = 8'h21;
         4'd8:    ch = 8'h21;
         4'd9:    ch = 8'h21;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cnad_front.sv -----
// Front end: accepts archive bytes, tracks the framing and queues result commands.
`default_nettype none

module cnad_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] archive_byte
   input  wire logic                   q_full,
   output cnad_pkg::cnad_push_type     push
);

   cnad_pkg::cnad_phase_type phase_ff, phase_in;
   logic [6:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] acc_ff [cnad_pkg::NUM_FIELDS];
   logic [31:0] acc_in [cnad_pkg::NUM_FIELDS];
   logic        halted_ff, halted_in;
   logic [31:0] name_rem_ff, name_rem_in;
   logic [3:0]  name_pos_ff, name_pos_in;
   logic        trail_ff, trail_in;
   logic [31:0] data_rem_ff, data_rem_in;
   logic [1:0]  offs_ff, offs_in;

   logic        accept;
   logic [7:0]  in_byte;
   logic        hdr_magic, magic_ok, hdr_last, name_empty;
   logic        hex_ok;
   logic [7:0]  hex_full;
   logic [6:0]  sub_idx;
   logic [3:0]  fld;
   logic        fld_first, halt_eff;
   logic [31:0] acc_cur, acc_new;
   logic [3:0]  name_pos_step;
   logic        trail_step, name_done, name_is_end, data_done;
   logic [1:0]  offs_step;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & ~q_full;
   assign in_byte    = req_tdata;

   // Magic check
   assign hdr_magic = hdr_idx_ff < cnad_pkg::MAGIC_LEN;
   assign magic_ok  = (hdr_idx_ff == cnad_pkg::MAGIC_LAST_IDX) ?
                      ((in_byte == cnad_pkg::CHAR_1) || (in_byte == cnad_pkg::CHAR_2)) :
                      (in_byte == cnad_pkg::magic_char(hdr_idx_ff[2:0]));
   assign hdr_last  = hdr_idx_ff == cnad_pkg::HDR_LAST_IDX;

   // Hex digit decode
   always_comb begin
      hex_ok   = 1'b1;
      hex_full = 8'd0;
      priority if ((in_byte >= cnad_pkg::CHAR_0) && (in_byte <= cnad_pkg::CHAR_9)) begin
         hex_full = in_byte - cnad_pkg::OFFSET_DIG;
      end else if ((in_byte >= cnad_pkg::CHAR_UA) && (in_byte <= cnad_pkg::CHAR_UF)) begin
         hex_full = in_byte - cnad_pkg::OFFSET_UC;
      end else if ((in_byte >= cnad_pkg::CHAR_LA) && (in_byte <= cnad_pkg::CHAR_LF)) begin
         hex_full = in_byte - cnad_pkg::OFFSET_LC;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Field accumulation
   assign sub_idx   = hdr_idx_ff - cnad_pkg::MAGIC_LEN;
   assign fld       = (sub_idx[6:3] > cnad_pkg::LAST_FIELD) ? cnad_pkg::LAST_FIELD : sub_idx[6:3];
   assign fld_first = sub_idx[2:0] == 3'd0;
   assign acc_cur   = fld_first ? 32'd0 : acc_ff[fld];
   assign halt_eff  = fld_first ? 1'b0 : halted_ff;
   assign acc_new   = (halt_eff || !hex_ok) ? acc_cur : {acc_cur[27:0], hex_full[3:0]};
   assign name_empty = acc_ff[cnad_pkg::FIELD_NAMESIZE] == 32'd0;

   // Name tracking and trailer test
   assign name_pos_step = (name_pos_ff < cnad_pkg::TRAILER_LEN) ? name_pos_ff + 4'd1 : name_pos_ff;
   assign trail_step    = trail_ff & ((name_pos_ff >= cnad_pkg::TRAILER_LEN) ||
                                      (in_byte == cnad_pkg::trailer_char(name_pos_ff)));
   assign name_done     = name_rem_ff == 32'd1;
   assign name_is_end   = trail_step && (name_pos_step >= cnad_pkg::TRAILER_LEN);
   assign data_done     = data_rem_ff == 32'd1;
   assign offs_step     = offs_ff + 2'd1;

   // Next state
   always_comb begin
      cnad_pkg::cnad_phase_type ph_mid;
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      acc_in      = acc_ff;
      halted_in   = halted_ff;
      name_rem_in = name_rem_ff;
      name_pos_in = name_pos_ff;
      trail_in    = trail_ff;
      data_rem_in = data_rem_ff;
      offs_in     = offs_ff;
      ph_mid      = phase_ff;
      if (accept && (phase_ff != cnad_pkg::PH_STOP)) begin
         offs_in = offs_step;
         unique case (phase_ff)
            cnad_pkg::PH_HEADER: begin
               if (hdr_magic && !magic_ok) begin
                  ph_mid = cnad_pkg::PH_STOP;
               end else begin
                  if (!hdr_magic) begin
                     acc_in[fld] = acc_new;
                     halted_in   = halt_eff | ~hex_ok;
                  end
                  if (hdr_last) begin
                     hdr_idx_in  = 7'd0;
                     name_rem_in = acc_ff[cnad_pkg::FIELD_NAMESIZE];
                     name_pos_in = 4'd0;
                     trail_in    = 1'b1;
                     if (name_empty) begin
                        data_rem_in = acc_ff[cnad_pkg::FIELD_FILESIZE];
                        ph_mid      = cnad_pkg::PH_NAME_PAD;
                     end else begin
                        ph_mid = cnad_pkg::PH_NAME;
                     end
                  end else begin
                     hdr_idx_in = hdr_idx_ff + 7'd1;
                  end
               end
            end
            cnad_pkg::PH_NAME: begin
               name_pos_in = name_pos_step;
               trail_in    = trail_step;
               name_rem_in = name_rem_ff - 32'd1;
               if (name_done) begin
                  if (name_is_end) begin
                     ph_mid = cnad_pkg::PH_STOP;
                  end else begin
                     data_rem_in = acc_ff[cnad_pkg::FIELD_FILESIZE];
                     ph_mid      = cnad_pkg::PH_NAME_PAD;
                  end
               end
            end
            cnad_pkg::PH_DATA: begin
               data_rem_in = data_rem_ff - 32'd1;
               if (data_done) begin
                  ph_mid = cnad_pkg::PH_DATA_PAD;
               end
            end
            default: begin
               ph_mid = phase_ff;
            end
         endcase
         // Leave padding at a 4-byte boundary
         if ((ph_mid == cnad_pkg::PH_NAME_PAD) && (offs_step == 2'd0)) begin
            ph_mid = (data_rem_in != 32'd0) ? cnad_pkg::PH_DATA : cnad_pkg::PH_DATA_PAD;
         end
         if ((ph_mid == cnad_pkg::PH_DATA_PAD) && (offs_step == 2'd0)) begin
            ph_mid = cnad_pkg::PH_HEADER;
         end
         phase_in = ph_mid;
      end
   end

   // Queue command for the results of this byte
   always_comb begin
      push.valid                    = 1'b0;
      push.cmd.kind_a               = cnad_pkg::KIND_NAME;
      push.cmd.has_second           = 1'b0;
      push.cmd.kind_b               = cnad_pkg::KIND_ENTRY;
      push.cmd.byte_value           = in_byte;
      push.cmd.rec.inode            = acc_ff[0];
      push.cmd.rec.file_mode        = acc_ff[1];
      push.cmd.rec.owner_uid        = acc_ff[2];
      push.cmd.rec.owner_gid        = acc_ff[3];
      push.cmd.rec.link_count       = acc_ff[4];
      push.cmd.rec.mod_time         = acc_ff[5];
      push.cmd.rec.data_length      = acc_ff[6];
      push.cmd.rec.device_pair      = {acc_ff[7], acc_ff[8]};
      push.cmd.rec.ref_device_pair  = {acc_ff[9], acc_ff[10]};
      if (accept) begin
         unique case (phase_ff)
            cnad_pkg::PH_HEADER: begin
               if (hdr_magic && !magic_ok) begin
                  push.valid      = 1'b1;
                  push.cmd.kind_a = cnad_pkg::KIND_BAD;
               end else if (hdr_last && name_empty) begin
                  push.valid      = 1'b1;
                  push.cmd.kind_a = cnad_pkg::KIND_ENTRY;
               end
            end
            cnad_pkg::PH_NAME: begin
               push.valid          = 1'b1;
               push.cmd.kind_a     = cnad_pkg::KIND_NAME;
               push.cmd.has_second = name_done;
               push.cmd.kind_b     = name_is_end ? cnad_pkg::KIND_END : cnad_pkg::KIND_ENTRY;
            end
            cnad_pkg::PH_DATA: begin
               push.valid      = 1'b1;
               push.cmd.kind_a = data_done ? cnad_pkg::KIND_LAST : cnad_pkg::KIND_DATA;
            end
            default: begin
               push.valid = 1'b0;
            end
         endcase
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cnad_pkg::PH_HEADER;
         hdr_idx_ff  <= 7'd0;
         halted_ff   <= 1'b0;
         name_rem_ff <= 32'd0;
         name_pos_ff <= 4'd0;
         trail_ff    <= 1'b1;
         data_rem_ff <= 32'd0;
         offs_ff     <= 2'd0;
         for (int i = 0; i < cnad_pkg::NUM_FIELDS; i++) begin
            acc_ff[i] <= 32'd0;
         end
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         halted_ff   <= halted_in;
         name_rem_ff <= name_rem_in;
         name_pos_ff <= name_pos_in;
         trail_ff    <= trail_in;
         data_rem_ff <= data_rem_in;
         offs_ff     <= offs_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cnad_queue.sv -----
// Short command queue between the parser front end and the result back end.
`default_nettype none

module cnad_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cnad_pkg::cnad_push_type push,
   output logic                      full,
   output cnad_pkg::cnad_head_type   head,
   input  wire logic                 pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cnad_pkg::cnad_cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == CNT_FULL;
   assign head.valid = count_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid & ~full;
   assign do_pop     = pop & head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cnad_back.sv -----
// Back end: expands queued commands into result transfers through an output register.
`default_nettype none

module cnad_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cnad_pkg::cnad_head_type head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [359:0]                rsp_tdata,
   output logic                        rsp_tlast,
   output logic [2:0]                  rsp_tuser
);

   logic                    valid_ff, valid_in;
   logic                    second_ff, second_in;
   cnad_pkg::cnad_kind_type kind_ff, kind_in;
   logic                    last_ff, last_in;
   logic [7:0]              byte_ff, byte_in;
   cnad_pkg::cnad_rec_type  rec_ff, rec_in;
   logic                    load;

   assign load = ~valid_ff | rsp_tready;

   // Pick the next result from the queue head
   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      byte_in   = byte_ff;
      rec_in    = rec_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            if (second_ff) begin
               kind_in   = head.cmd.kind_b;
               last_in   = 1'b1;
               pop       = 1'b1;
               second_in = 1'b0;
            end else begin
               kind_in   = head.cmd.kind_a;
               last_in   = ~head.cmd.has_second;
               pop       = ~head.cmd.has_second;
               second_in = head.cmd.has_second;
            end
            // Zero the fields that do not belong to this kind
            unique case (kind_in)
               cnad_pkg::KIND_NAME,
               cnad_pkg::KIND_DATA,
               cnad_pkg::KIND_LAST: byte_in = head.cmd.byte_value;
               default:             byte_in = 8'd0;
            endcase
            rec_in = (kind_in == cnad_pkg::KIND_ENTRY) ? head.cmd.rec : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      last_ff <= last_in;
      byte_ff <= byte_in;
      rec_ff  <= rec_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {rec_ff.ref_device_pair, rec_ff.device_pair, rec_ff.data_length,
                        rec_ff.mod_time, rec_ff.link_count, rec_ff.owner_gid,
                        rec_ff.owner_uid, rec_ff.file_mode, rec_ff.inode, byte_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/cpio_newc_archive_deframer.sv -----
// Top level of the cpio newc archive deframer.
//
// The req channel takes one archive byte per transfer. The rsp channel gives
// one result per transfer: tuser holds the kind (name byte, entry record, data
// byte, last data byte, end of archive, bad format), tlast marks the final
// result caused by one archive byte, tdata holds the byte and, in an entry
// record, the decoded header values.
// A byte is accepted every cycle while the command queue has room; its first
// result goes through the queue and then the rsp register. Each byte gives at
// most one queue command; the last name byte gives two results, sent one after
// the other by the back end, so one input byte per cycle is sustained except
// when these double results pile up faster than the rsp side drains. Header,
// padding and stopped-phase bytes give no result, save a bad magic byte (bad
// format) and the last header byte of an entry with namesize zero (its record).
// Reset returns the parser to the header phase, empties the queue and drops
// rsp_tvalid. A stalled receiver holds the rsp register; the queue of
// QUEUE_DEPTH commands then fills and req_tready falls.
// After a bad magic or the end-of-archive marker all bytes are consumed
// without result until reset.
`default_nettype none

module cpio_newc_archive_deframer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] archive_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] byte_value, [39:8] inode, [71:40] file_mode, [103:72] owner_uid,
   // [135:104] owner_gid, [167:136] link_count, [199:168] mod_time,
   // [231:200] data_length, [295:232] device_pair, [359:296] ref_device_pair
   output logic [359:0]      rsp_tdata,
   output logic              rsp_tlast,   // last_of_run
   output logic [2:0]        rsp_tuser    // [2:0] kind
);

   cnad_pkg::cnad_push_type push;
   cnad_pkg::cnad_head_type head;
   logic                    q_full;
   logic                    pop;

   cnad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push)
   );

   cnad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   cnad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
